// ===== design/slhm_pkg.sv =====
// Package of the stamp link health monitor: field widths, register indexes,
// reset values of the configuration registers, status levels and states.
// Depends on nothing; every other file of the block imports it.
package slhm_pkg;

   localparam int TIME_W    = 48;
   localparam int DELAY_W   = TIME_W + 1;
   localparam int CFG_W     = 32;
   localparam int RE_W      = 8;
   localparam int CSR_IDX_W = 8;
   localparam int COUNT_W   = 5;
   localparam int MAXD_W    = TIME_W - 1;

   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DELAY    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_INTERVAL = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_REPORT_EVERY = CSR_IDX_W'(3);

   localparam logic [CFG_W-1:0] TIMEOUT_RESET      = CFG_W'(1000000);
   localparam logic [CFG_W-1:0] MAX_DELAY_RESET    = CFG_W'(150000);
   localparam logic [CFG_W-1:0] MAX_INTERVAL_RESET = CFG_W'(0);
   localparam logic [RE_W-1:0]  REPORT_EVERY_RESET = RE_W'(10);

   typedef enum logic [1:0] {
      LEVEL_OK    = 2'd0,
      LEVEL_WARN  = 2'd1,
      LEVEL_ERROR = 2'd2
   } level_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_START,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

// ===== design/slhm_req_if.sv =====
// Input channel of the stamp link health monitor: one tick per transaction.
// Depends on slhm_pkg for the field widths.
interface slhm_req_if import slhm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_us;
   logic [TIME_W-1:0] latest_stamp_us;

   modport source (output valid, now_us, latest_stamp_us, input ready);
   modport sink   (input valid, now_us, latest_stamp_us, output ready);
endinterface

// ===== design/slhm_rsp_if.sv =====
// Result channel of the stamp link health monitor: one report per transaction.
// Depends on slhm_pkg for the field widths.
interface slhm_rsp_if import slhm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               level;
   logic                     alive;
   logic                     timed_out;
   logic                     stats_valid;
   logic                     high_delay;
   logic                     low_rate;
   logic [COUNT_W-1:0]       window_count;
   logic [MAXD_W-1:0]        max_delay_us;
   logic signed [TIME_W-1:0] avg_delay_us;
   logic signed [TIME_W-1:0] avg_interval_us;
   logic signed [TIME_W-1:0] elapsed_us;

   modport source (output valid, level, alive, timed_out, stats_valid, high_delay,
                   low_rate, window_count, max_delay_us, avg_delay_us,
                   avg_interval_us, elapsed_us, input ready);
   modport sink   (input valid, level, alive, timed_out, stats_valid, high_delay,
                   low_rate, window_count, max_delay_us, avg_delay_us,
                   avg_interval_us, elapsed_us, output ready);
endinterface

// ===== design/slhm_csr_if.sv =====
// Configuration write channel of the stamp link health monitor.
// Depends on slhm_pkg for the index and data widths.
interface slhm_csr_if import slhm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/slhm_cell.sv =====
// One window cell: holds a stamp and time pair and takes its left neighbor's
// pair whenever the chain shifts. Depends on slhm_pkg for the time width.
module slhm_cell import slhm_pkg::*; (
   input  logic              clock,
   input  logic              shift_en,
   input  logic [TIME_W-1:0] left_stamp,
   input  logic [TIME_W-1:0] left_now,
   output logic [TIME_W-1:0] stamp,
   output logic [TIME_W-1:0] now
);

   logic [TIME_W-1:0] stamp_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] stamp_in;
   logic [TIME_W-1:0] now_in;

   always_comb begin
      stamp_in = shift_en ? left_stamp : stamp_ff;
      now_in   = shift_en ? left_now : now_ff;
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
      now_ff   <= now_in;
   end

   assign stamp = stamp_ff;
   assign now   = now_ff;

endmodule

// ===== design/slhm_div.sv =====
// Iterative signed divider, four quotient bits per cycle, truncating toward
// zero, for a narrow unsigned divisor. Depends on slhm_pkg only by convention.
module slhm_div import slhm_pkg::*; #(
   parameter int NUM_W = 54,
   parameter int DEN_W = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0]        divisor,
   output logic signed [NUM_W-1:0] quotient,
   output logic                    done
);

   localparam int DIGITS = 4;
   localparam int ITER   = (NUM_W + DIGITS - 1) / DIGITS;
   localparam int PAD_W  = ITER * DIGITS;
   localparam int ITER_W = $clog2(ITER);
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ITER - 1);

   logic [PAD_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NUM_W-1:0]  abs_val;
   logic [NUM_W-1:0]  mag;

   assign abs_val = dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;

   always_comb begin
      logic [PAD_W-1:0] q;
      logic [DEN_W:0]   r;
      q       = quo_ff;
      r       = rem_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = PAD_W'(abs_val);
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[NUM_W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         for (int k = 0; k < DIGITS; k++) begin
            r = {r[DEN_W-1:0], q[PAD_W-1]};
            q = {q[PAD_W-2:0], 1'b0};
            if (r >= {1'b0, den_ff}) begin
               r    = r - {1'b0, den_ff};
               q[0] = 1'b1;
            end
         end
         quo_in = q;
         rem_in = r;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_ITER) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign mag      = quo_ff[NUM_W-1:0];
   assign quotient = $signed(neg_ff ? (~mag + 1'b1) : mag);
   assign done     = done_ff;

endmodule

// ===== design/stamp_link_health_monitor.sv =====
// Stamp link health monitor. A tick is taken when the block is idle; it then
// rotates its cell chain once; a reported tick then starts the delay and interval
// dividers and, once both are done, loads the output register, waiting while a
// held report waits for the sink. A synchronous reset empties the window, clears
// the tick counter and loads the register defaults; cell contents are not cleared.
module stamp_link_health_monitor import slhm_pkg::*; #(
   parameter int WINDOW_DEPTH = 20
) (
   input  logic clock,
   input  logic reset,
   slhm_req_if.sink   req_chan,
   slhm_rsp_if.source rsp_chan,
   slhm_csr_if.sink   csr_chan
);

   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int STEP_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = DELAY_W + $clog2(WINDOW_DEPTH);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);

   state_type state_ff, state_in;

   logic [CFG_W-1:0] timeout_ff, timeout_in;
   logic [CFG_W-1:0] max_delay_ff, max_delay_in;
   logic [CFG_W-1:0] max_ival_ff, max_ival_in;
   logic [RE_W-1:0]  report_ff, report_in;

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [RE_W-1:0]   tick_ff, tick_in;
   logic              emit_ff, emit_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] stamp_ff, stamp_in;

   logic signed [SUM_W-1:0] dsum_ff, dsum_in;
   logic signed [SUM_W-1:0] isum_ff, isum_in;
   logic [CNT_W-1:0]        icnt_ff, icnt_in;
   logic [TIME_W-1:0]       dmax_ff, dmax_in;
   logic [TIME_W-1:0]       prev_ff, prev_in;

   logic accept, shift_en, div_start, rsp_load, last_step, divs_done;

   logic [TIME_W-1:0] link_stamp [WINDOW_DEPTH+1];
   logic [TIME_W-1:0] link_now [WINDOW_DEPTH+1];
   logic [TIME_W-1:0] tail_stamp, tail_now;
   logic              entry_valid;

   logic signed [SUM_W-1:0] q_delay, q_ival;
   logic                    done_delay, done_ival;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               level_ff, level_in;
   logic                     alive_ff, alive_in;
   logic                     tout_ff, tout_in;
   logic                     svalid_ff, svalid_in;
   logic                     high_ff, high_in;
   logic                     low_ff, low_in;
   logic [COUNT_W-1:0]       wcount_ff, wcount_in;
   logic [MAXD_W-1:0]        maxd_ff, maxd_in;
   logic signed [TIME_W-1:0] avgd_ff, avgd_in;
   logic signed [TIME_W-1:0] avgi_ff, avgi_in;
   logic signed [TIME_W-1:0] elap_ff, elap_in;

   function automatic logic [TIME_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-TIME_W:0] top;
      top = v[SUM_W-1:TIME_W-1];
      if (&top || ~|top) begin
         return v[TIME_W-1:0];
      end
      return v[SUM_W-1] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
   endfunction

   // Configuration registers.
   assign csr_chan.ready = 1'b1;

   always_comb begin
      timeout_in   = timeout_ff;
      max_delay_in = max_delay_ff;
      max_ival_in  = max_ival_ff;
      report_in    = report_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_TIMEOUT:      timeout_in   = csr_chan.data;
            REG_MAX_DELAY:    max_delay_in = csr_chan.data;
            REG_MAX_INTERVAL: max_ival_in  = csr_chan.data;
            REG_REPORT_EVERY: report_in    = csr_chan.data[RE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control sequencer.
   assign accept    = req_chan.valid && req_chan.ready;
   assign last_step = step_ff == LAST_STEP;
   assign divs_done = done_delay && done_ival;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (last_step) state_in = emit_ff ? ST_START : ST_IDLE;
         end
         ST_START: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (divs_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      shift_en       = 1'b0;
      div_start      = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            shift_en       = req_chan.valid;
         end
         ST_WALK:   shift_en  = 1'b1;
         ST_START:  div_start = 1'b1;
         ST_DIVIDE: begin
         end
         ST_FINISH: rsp_load = !rsp_valid_ff || rsp_chan.ready;
         default: begin
         end
      endcase
   end

   // Cell chain: a tick shifts in at the head; the walk rotates the tail back
   // to the head so the chain holds the same window after a full pass.
   assign tail_stamp    = link_stamp[WINDOW_DEPTH];
   assign tail_now      = link_now[WINDOW_DEPTH];
   assign link_stamp[0] = (state_ff == ST_IDLE) ? req_chan.latest_stamp_us : tail_stamp;
   assign link_now[0]   = (state_ff == ST_IDLE) ? req_chan.now_us : tail_now;

   for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      slhm_cell u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .left_stamp (link_stamp[g]),
         .left_now   (link_now[g]),
         .stamp      (link_stamp[g+1]),
         .now        (link_now[g+1])
      );
   end

   // The tail shows the oldest cell first; empty cells come out before the
   // filled ones and are skipped.
   assign entry_valid = ((CNT_W+1)'(step_ff) + (CNT_W+1)'(fill_ff))
                        >= (CNT_W+1)'(WINDOW_DEPTH);

   always_comb begin
      logic signed [DELAY_W-1:0] d;
      logic signed [DELAY_W-1:0] ival;
      logic [RE_W-1:0]           tick_next;
      logic [RE_W-1:0]           limit;
      d         = $signed({1'b0, tail_now}) - $signed({1'b0, tail_stamp});
      ival      = $signed({1'b0, tail_stamp}) - $signed({1'b0, prev_ff});
      tick_next = tick_ff + 1'b1;
      limit     = (report_ff == '0) ? RE_W'(1) : report_ff;
      fill_in   = fill_ff;
      tick_in   = tick_ff;
      emit_in   = emit_ff;
      step_in   = step_ff;
      now_in    = now_ff;
      stamp_in  = stamp_ff;
      dsum_in   = dsum_ff;
      isum_in   = isum_ff;
      icnt_in   = icnt_ff;
      dmax_in   = dmax_ff;
      prev_in   = prev_ff;
      if (accept) begin
         if (fill_ff != DEPTH_CNT) fill_in = fill_ff + 1'b1;
         emit_in  = tick_next >= limit;
         tick_in  = (tick_next >= limit) ? '0 : tick_next;
         step_in  = '0;
         now_in   = req_chan.now_us;
         stamp_in = req_chan.latest_stamp_us;
         dsum_in  = '0;
         isum_in  = '0;
         icnt_in  = '0;
         dmax_in  = '0;
         prev_in  = '0;
      end else if (state_ff == ST_WALK) begin
         step_in = step_ff + 1'b1;
         if (entry_valid) begin
            dsum_in = dsum_ff + SUM_W'(d);
            if (d > $signed({1'b0, dmax_ff})) dmax_in = d[TIME_W-1:0];
            if (tail_stamp != prev_ff) begin
               if (prev_ff != '0) begin
                  isum_in = isum_ff + SUM_W'(ival);
                  icnt_in = icnt_ff + 1'b1;
               end
               prev_in = tail_stamp;
            end
         end
      end
   end

   slhm_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_delay (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dsum_ff),
      .divisor  (fill_ff),
      .quotient (q_delay),
      .done     (done_delay)
   );

   slhm_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_ival (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (isum_ff),
      .divisor  (icnt_ff),
      .quotient (q_ival),
      .done     (done_ival)
   );

   // Report assembly into the output register.
   always_comb begin
      logic signed [DELAY_W-1:0] elapsed;
      logic [CFG_W+1:0]          triple;
      logic signed [SUM_W-1:0]   avg_ival;
      logic                      timed, valid, high, low;
      logic [7:0]                fill_ext;
      level_type                 lvl;
      elapsed  = $signed({1'b0, now_ff}) - $signed({1'b0, stamp_ff});
      triple   = {2'b00, timeout_ff} + {1'b0, timeout_ff, 1'b0};
      avg_ival = (icnt_ff == '0) ? '0 : q_ival;
      timed    = elapsed > $signed(DELAY_W'(timeout_ff));
      valid    = fill_ff > CNT_W'(1);
      high     = valid && !timed && (max_delay_ff != '0)
                 && (q_delay > $signed(SUM_W'(max_delay_ff)));
      low      = valid && !timed && (max_ival_ff != '0)
                 && (avg_ival > $signed(SUM_W'(max_ival_ff)));
      fill_ext = 8'(fill_ff);
      if (stamp_ff == '0) begin
         lvl = LEVEL_WARN;
      end else if (timed) begin
         lvl = LEVEL_ERROR;
      end else begin
         lvl = LEVEL_OK;
      end
      if ((high || low) && lvl == LEVEL_OK) lvl = LEVEL_WARN;

      rsp_valid_in = rsp_valid_ff;
      level_in     = level_ff;
      alive_in     = alive_ff;
      tout_in      = tout_ff;
      svalid_in    = svalid_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      wcount_in    = wcount_ff;
      maxd_in      = maxd_ff;
      avgd_in      = avgd_ff;
      avgi_in      = avgi_ff;
      elap_in      = elap_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         level_in     = lvl;
         alive_in     = !(elapsed > $signed(DELAY_W'(triple)));
         tout_in      = timed;
         svalid_in    = valid;
         high_in      = high;
         low_in       = low;
         wcount_in    = (fill_ext > 8'd31) ? COUNT_W'(31) : fill_ext[COUNT_W-1:0];
         maxd_in      = dmax_ff[TIME_W-1] ? {MAXD_W{1'b1}} : dmax_ff[MAXD_W-1:0];
         avgd_in      = $signed(sat_sum(q_delay));
         avgi_in      = $signed(sat_sum(avg_ival));
         elap_in      = $signed(sat_sum(SUM_W'(elapsed)));
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         max_delay_ff <= MAX_DELAY_RESET;
         max_ival_ff  <= MAX_INTERVAL_RESET;
         report_ff    <= REPORT_EVERY_RESET;
         fill_ff      <= '0;
         tick_ff      <= '0;
         emit_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         max_delay_ff <= max_delay_in;
         max_ival_ff  <= max_ival_in;
         report_ff    <= report_in;
         fill_ff      <= fill_in;
         tick_ff      <= tick_in;
         emit_ff      <= emit_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff    <= now_in;
      stamp_ff  <= stamp_in;
      dsum_ff   <= dsum_in;
      isum_ff   <= isum_in;
      icnt_ff   <= icnt_in;
      dmax_ff   <= dmax_in;
      prev_ff   <= prev_in;
      level_ff  <= level_in;
      alive_ff  <= alive_in;
      tout_ff   <= tout_in;
      svalid_ff <= svalid_in;
      high_ff   <= high_in;
      low_ff    <= low_in;
      wcount_ff <= wcount_in;
      maxd_ff   <= maxd_in;
      avgd_ff   <= avgd_in;
      avgi_ff   <= avgi_in;
      elap_ff   <= elap_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.level           = level_ff;
   assign rsp_chan.alive           = alive_ff;
   assign rsp_chan.timed_out       = tout_ff;
   assign rsp_chan.stats_valid     = svalid_ff;
   assign rsp_chan.high_delay      = high_ff;
   assign rsp_chan.low_rate        = low_ff;
   assign rsp_chan.window_count    = wcount_ff;
   assign rsp_chan.max_delay_us    = maxd_ff;
   assign rsp_chan.avg_delay_us    = avgd_ff;
   assign rsp_chan.avg_interval_us = avgi_ff;
   assign rsp_chan.elapsed_us      = elap_ff;

endmodule

// ===== verif/slhm_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard of the stamp link health monitor bench: follows register writes and
// accepted ticks, predicts every report and checks each one field by field.
// Depends on slhm_pkg and the request, result and register channel interfaces.
module slhm_checker import slhm_pkg::*; #(
   parameter int WINDOW_DEPTH = 20
) (
   input  logic clock,
   input  logic reset,
   slhm_req_if  req_mon,
   slhm_rsp_if  rsp_mon,
   slhm_csr_if  csr_mon,
   output int   fail_count,
   output int   outstanding
);

   localparam longint SAT_HI = (64'sd1 <<< (TIME_W - 1)) - 64'sd1;
   localparam longint SAT_LO = -(64'sd1 <<< (TIME_W - 1));

   typedef struct {
      level_type                level;
      logic                     alive;
      logic                     timed_out;
      logic                     stats_valid;
      logic                     high_delay;
      logic                     low_rate;
      logic [COUNT_W-1:0]       window_count;
      logic [MAXD_W-1:0]        max_delay_us;
      logic signed [TIME_W-1:0] avg_delay_us;
      logic signed [TIME_W-1:0] avg_interval_us;
      logic signed [TIME_W-1:0] elapsed_us;
   } health_report_type;

   logic [TIME_W-1:0] stamp_ring [WINDOW_DEPTH];
   logic [TIME_W-1:0] now_ring [WINDOW_DEPTH];
   int                ring_head;
   int                ring_fill;
   logic [RE_W-1:0]   tick_count;
   logic [CFG_W-1:0]  timeout_us;
   logic [CFG_W-1:0]  max_avg_delay_us;
   logic [CFG_W-1:0]  max_avg_interval_us;
   logic [RE_W-1:0]   report_every;
   health_report_type expected_reports [$];
   int                mismatches = 0;
   int                queued = 0;

   assign fail_count  = mismatches;
   assign outstanding = queued;

   function automatic logic signed [TIME_W-1:0] clip_time(input longint value);
      if (value > SAT_HI) begin
         return TIME_W'(SAT_HI);
      end
      if (value < SAT_LO) begin
         return TIME_W'(SAT_LO);
      end
      return TIME_W'(value);
   endfunction

   task automatic take_tick(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] stamp);
      longint            elapsed;
      longint            delay;
      longint            delay_sum;
      longint            max_delay;
      longint            gap_sum;
      longint            gap_count;
      longint            avg_delay;
      longint            avg_gap;
      logic [TIME_W-1:0] prev_stamp;
      int                slot;
      logic [RE_W-1:0]   limit;
      health_report_type report;
      stamp_ring[ring_head] = stamp;
      now_ring[ring_head] = now;
      ring_head = (ring_head + 1) % WINDOW_DEPTH;
      if (ring_fill < WINDOW_DEPTH) begin
         ring_fill++;
      end
      elapsed = longint'({16'd0, now}) - longint'({16'd0, stamp});
      delay_sum = 0;
      max_delay = 0;
      gap_sum = 0;
      gap_count = 0;
      prev_stamp = '0;
      for (int i = 0; i < ring_fill; i++) begin
         slot = (ring_head + WINDOW_DEPTH - ring_fill + i) % WINDOW_DEPTH;
         delay = longint'({16'd0, now_ring[slot]}) - longint'({16'd0, stamp_ring[slot]});
         delay_sum += delay;
         if (delay > max_delay) begin
            max_delay = delay;
         end
         if (stamp_ring[slot] != prev_stamp) begin
            if (prev_stamp != '0) begin
               gap_sum += longint'({16'd0, stamp_ring[slot]}) - longint'({16'd0, prev_stamp});
               gap_count++;
            end
            prev_stamp = stamp_ring[slot];
         end
      end
      tick_count = tick_count + 1'b1;
      limit = (report_every == '0) ? RE_W'(1) : report_every;
      if (tick_count < limit) begin
         return;
      end
      tick_count = '0;
      avg_delay = delay_sum / longint'(ring_fill);
      avg_gap = (gap_count > 0) ? gap_sum / gap_count : 0;
      report.timed_out = (elapsed > longint'({32'd0, timeout_us}));
      report.alive = !(elapsed > 3 * longint'({32'd0, timeout_us}));
      report.stats_valid = (ring_fill > 1);
      report.high_delay = report.stats_valid && !report.timed_out
         && max_avg_delay_us != '0 && avg_delay > longint'({32'd0, max_avg_delay_us});
      report.low_rate = report.stats_valid && !report.timed_out
         && max_avg_interval_us != '0 && avg_gap > longint'({32'd0, max_avg_interval_us});
      if (stamp == '0) begin
         report.level = LEVEL_WARN;
      end else if (report.timed_out) begin
         report.level = LEVEL_ERROR;
      end else begin
         report.level = LEVEL_OK;
      end
      if ((report.high_delay || report.low_rate) && report.level == LEVEL_OK) begin
         report.level = LEVEL_WARN;
      end
      report.window_count = COUNT_W'((ring_fill > 31) ? 31 : ring_fill);
      report.max_delay_us = MAXD_W'((max_delay > SAT_HI) ? SAT_HI : max_delay);
      report.avg_delay_us = clip_time(avg_delay);
      report.avg_interval_us = clip_time(avg_gap);
      report.elapsed_us = clip_time(elapsed);
      expected_reports.insert(expected_reports.size(), report);
   endtask

   task automatic compare_field(input string name, input logic signed [63:0] want_value,
                                input logic signed [63:0] got_value);
      if (got_value !== want_value) begin
         $error("%s: expected %0d, got %0d", name, want_value, got_value);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      health_report_type want;
      if (reset) begin
         ring_head = 0;
         ring_fill = 0;
         tick_count = '0;
         timeout_us = TIMEOUT_RESET;
         max_avg_delay_us = MAX_DELAY_RESET;
         max_avg_interval_us = MAX_INTERVAL_RESET;
         report_every = REPORT_EVERY_RESET;
         expected_reports.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_TIMEOUT: timeout_us = csr_mon.data;
               REG_MAX_DELAY: max_avg_delay_us = csr_mon.data;
               REG_MAX_INTERVAL: max_avg_interval_us = csr_mon.data;
               REG_REPORT_EVERY: report_every = csr_mon.data[RE_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            take_tick(req_mon.now_us, req_mon.latest_stamp_us);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reports.size() == 0) begin
               $error("report transaction arrived with no report expected");
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("level", want.level, rsp_mon.level);
               compare_field("alive", want.alive, rsp_mon.alive);
               compare_field("timed_out", want.timed_out, rsp_mon.timed_out);
               compare_field("stats_valid", want.stats_valid, rsp_mon.stats_valid);
               compare_field("high_delay", want.high_delay, rsp_mon.high_delay);
               compare_field("low_rate", want.low_rate, rsp_mon.low_rate);
               compare_field("window_count", want.window_count, rsp_mon.window_count);
               compare_field("max_delay_us", want.max_delay_us, rsp_mon.max_delay_us);
               compare_field("avg_delay_us", want.avg_delay_us, rsp_mon.avg_delay_us);
               compare_field("avg_interval_us", want.avg_interval_us,
                             rsp_mon.avg_interval_us);
               compare_field("elapsed_us", want.elapsed_us, rsp_mon.elapsed_us);
            end
         end
      end
      queued = expected_reports.size();
   end

endmodule

// ===== verif/tb_stamp_link_health_monitor.sv =====
`timescale 1ns / 100ps
// Top of the stamp link health monitor bench: clock, reset, the block, its
// scoreboard, and the tick, report and register traffic that drives them.
// Depends on slhm_pkg, the channel interfaces, the block and slhm_checker.
module tb_stamp_link_health_monitor;
   import slhm_pkg::*;

   localparam int WINDOW_DEPTH  = 20;
   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 200;
   localparam int PHASES        = 14;
   localparam int PHASE_TICKS   = 120;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = CSR_IDX_W'(4);
   localparam logic [TIME_W-1:0]    TIME_MAX   = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   outstanding;
   int   calm_ticks = 0;

   slhm_req_if req_bus ();
   slhm_rsp_if rsp_bus ();
   slhm_csr_if csr_bus ();

   stamp_link_health_monitor #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   slhm_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] reg_index,
                            input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_tick(input logic [TIME_W-1:0] now_us,
                            input logic [TIME_W-1:0] stamp_us);
      int gap;
      if (calm_ticks > 0) begin
         calm_ticks--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 19) == 0) begin
            calm_ticks = $urandom_range(10, 40);
         end
         gap = $urandom_range(0, 5);
      end
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.now_us <= now_us;
      req_bus.latest_stamp_us <= stamp_us;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : report_pacing
      int stall;
      int taken;
      int calm_reports;
      taken = 0;
      calm_reports = 0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (taken == 30 || taken == 400) begin
            stall = HOLD_CYCLES;
         end else if (calm_reports > 0) begin
            calm_reports--;
            stall = 0;
         end else begin
            if ($urandom_range(0, 19) == 0) begin
               calm_reports = $urandom_range(10, 40);
            end
            stall = $urandom_range(0, 5);
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [TIME_W-1:0] tick_now;
      logic [TIME_W-1:0] tick_stamp;
      logic [TIME_W-1:0] link_now;
      logic [TIME_W-1:0] link_stamp;
      logic [TIME_W-1:0] spread;
      int                pick;
      req_bus.valid = 1'b0;
      req_bus.now_us = '0;
      req_bus.latest_stamp_us = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reg(REG_REPORT_EVERY, CFG_W'(1));
      write_reg(REG_MAX_INTERVAL, CFG_W'(5000));
      write_reg(REG_UNUSED, '1);
      send_tick(48'd1000, 48'd0);
      for (int k = 0; k < 5; k++) begin
         send_tick(TIME_W'(300000 + k * 60000), TIME_W'(100000 + k * 60000));
      end
      send_tick(48'd600000, 48'd340000);
      send_tick(48'd660000, 48'd0);
      send_tick(48'd2000000, 48'd500000);
      send_tick(48'd10000000, 48'd1000);
      send_tick(48'd100, 48'd900000);
      send_tick(TIME_MAX, 48'd0);
      send_tick(48'd0, TIME_MAX);
      send_tick(TIME_MAX, 48'd1);
      send_tick(TIME_MAX, TIME_MAX);
      send_tick(48'd1, TIME_MAX);

      link_now = 48'd5000000;
      link_stamp = 48'd4900000;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         if (phase == 0) begin
            write_reg(REG_TIMEOUT, '0);
            write_reg(REG_MAX_DELAY, '0);
            write_reg(REG_MAX_INTERVAL, '0);
            write_reg(REG_REPORT_EVERY, '0);
         end else if (phase == 1) begin
            write_reg(REG_TIMEOUT, '1);
            write_reg(REG_MAX_DELAY, '1);
            write_reg(REG_MAX_INTERVAL, '1);
            write_reg(REG_REPORT_EVERY, '1);
         end else begin
            pick = $urandom_range(0, 5);
            write_reg(REG_TIMEOUT, (pick == 0) ? CFG_W'($urandom) :
                      (pick == 1) ? '0 : CFG_W'($urandom_range(20000, 2000000)));
            pick = $urandom_range(0, 5);
            write_reg(REG_MAX_DELAY, (pick == 0) ? CFG_W'($urandom) :
                      (pick == 1) ? '0 : CFG_W'($urandom_range(1000, 300000)));
            pick = $urandom_range(0, 5);
            write_reg(REG_MAX_INTERVAL, (pick == 0) ? CFG_W'($urandom) :
                      (pick == 1) ? '0 : CFG_W'($urandom_range(1000, 80000)));
            pick = $urandom_range(0, 9);
            write_reg(REG_REPORT_EVERY, (pick == 0) ? CFG_W'($urandom) :
                      (pick == 1) ? '0 : CFG_W'($urandom_range(1, 12)));
         end
         for (int n = 0; n < PHASE_TICKS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               link_now = link_now + TIME_W'($urandom_range(1, 80000));
               if ($urandom_range(0, 3) != 0) begin
                  spread = TIME_W'($urandom_range(0, 400000));
                  link_stamp = (link_now > spread) ? link_now - spread : 48'd1;
               end
               tick_now = link_now;
               tick_stamp = link_stamp;
            end else if (pick < 72) begin
               link_now = link_now + TIME_W'($urandom_range(1, 80000));
               link_stamp = '0;
               tick_now = link_now;
               tick_stamp = link_stamp;
            end else if (pick < 82) begin
               link_now = link_now + TIME_W'($urandom_range(100000, 4000000));
               tick_now = link_now;
               tick_stamp = link_stamp;
            end else if (pick < 90) begin
               tick_now = link_now;
               tick_stamp = link_now + TIME_W'($urandom_range(1, 500000));
            end else begin
               tick_now = {16'($urandom), 32'($urandom)};
               tick_stamp = {16'($urandom), 32'($urandom)};
            end
            send_tick(tick_now, tick_stamp);
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #8000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
design/slhm_pkg.sv
design/slhm_req_if.sv
design/slhm_rsp_if.sv
design/slhm_csr_if.sv
design/slhm_cell.sv
design/slhm_div.sv
design/stamp_link_health_monitor.sv
verif/slhm_checker.sv
verif/tb_stamp_link_health_monitor.sv
